FILE: hdl/lrut_pkg.sv
// ----------------------------------------------------------------------------
// LRU list tracker package
// Sizes, link encoding, command codes and sequencer states shared by the
// list tracker and its testbench.
// ----------------------------------------------------------------------------
package lrut_pkg;

	localparam int ENTRIES = 64;
	localparam int ID_W    = 6;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int LINK_W  = $clog2(ENTRIES + 1);

	// A link equal to the entry count marks the end of the list.
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

	typedef enum logic [1:0] {
		CMD_TOUCH   = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_RECLAIM = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_UNLINK,
		S_SELF,
		S_LINK_HEAD
	} state_t;

	function automatic logic link_is_ref(input logic [LINK_W-1:0] l);
		return l < NULL_LINK;
	endfunction

endpackage

FILE: hdl/lru_list_tracker.sv
// ----------------------------------------------------------------------------
// LRU list tracker
// Recency order over numbered entries kept as a doubly linked list in two
// link memories, with head and tail pointers and a membership bit per entry.
// ----------------------------------------------------------------------------
// Usage:
// A command beat is taken on a rising edge where start is high and busy is
// low; cmd selects touch, remove, reclaim or clear, entry_id names the entry
// (or the keep entry of a reclaim, qualified by keep_valid).
// Every command gives exactly one result beat: done is high for one cycle
// with victim_valid, victim_id, was_listed and list_empty. The receiver
// cannot stall; the result must be taken in that cycle.
// The next and previous links of the addressed entry are read at the edge
// that takes the command; the neighbour updates then follow as single-write
// steps on each link memory, so the state path is set by those write ports:
//   clear, remove of an absent entry, touch of the head,
//   reclaim without a move: S_EVAL only
//   remove of a listed entry: S_EVAL, S_UNLINK
//   touch that inserts an absent entry: S_EVAL, S_SELF, S_LINK_HEAD
//   touch or reclaim that moves a listed entry to the head: S_EVAL, S_UNLINK,
//     S_SELF, S_LINK_HEAD; each path ends in the done cycle; a new
// command may be taken during the done cycle.
// After reset the list is empty and the block is idle; the link memories
// need no clearing since links are only used for listed entries.
// ----------------------------------------------------------------------------
module lru_list_tracker
	import lrut_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [1:0]      cmd,
	input  logic [ID_W-1:0] entry_id,
	input  logic            keep_valid,
	output logic            done,
	output logic            victim_valid,
	output logic [ID_W-1:0] victim_id,
	output logic            was_listed,
	output logic            list_empty
);

	state_t state_q, state_d;

	logic              accept;
	logic [IDX_W-1:0]  in_idx;
	logic              in_range;

	cmd_t              cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              keep_q;
	logic              inr_q;
	logic              lst_q;

	logic [ENTRIES-1:0] listed_q;
	logic [LINK_W-1:0]  head_q, head_d;
	logic [LINK_W-1:0]  tail_q, tail_d;
	logic               done_q, done_d;
	logic               lst_set, lst_clr, lst_clear_all;

	logic               next_we, prev_we;
	logic [IDX_W-1:0]   next_waddr, prev_waddr;
	logic [LINK_W-1:0]  next_wdata, prev_wdata;
	logic [LINK_W-1:0]  next_rd, prev_rd;
	logic [LINK_W-1:0]  self_link;
	logic               move_cmd;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign in_idx   = IDX_W'(entry_id);
	assign in_range = (int'(entry_id) < ENTRIES);
	assign self_link = LINK_W'(idx_q);
	assign move_cmd  = (cmd_q == CMD_TOUCH) || (cmd_q == CMD_RECLAIM && keep_q);

	lrut_link_ram #(.DEPTH(ENTRIES), .WIDTH(LINK_W)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (accept),
		.raddr (in_idx),
		.rdata (next_rd)
	);

	lrut_link_ram #(.DEPTH(ENTRIES), .WIDTH(LINK_W)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (accept),
		.raddr (in_idx),
		.rdata (prev_rd)
	);

	// Command beat capture; the membership bit is sampled with it.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(cmd);
			idx_q  <= in_idx;
			keep_q <= keep_valid;
			inr_q  <= in_range;
			lst_q  <= in_range && listed_q[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		tail_d        = tail_q;
		done_d        = 1'b0;
		lst_set       = 1'b0;
		lst_clr       = 1'b0;
		lst_clear_all = 1'b0;
		next_we       = 1'b0;
		next_waddr    = idx_q;
		next_wdata    = NULL_LINK;
		prev_we       = 1'b0;
		prev_waddr    = idx_q;
		prev_wdata    = NULL_LINK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				unique case (cmd_q)
					CMD_CLEAR: begin
						lst_clear_all = 1'b1;
						head_d        = NULL_LINK;
						tail_d        = NULL_LINK;
						done_d        = 1'b1;
						state_d       = S_IDLE;
					end
					CMD_REMOVE: begin
						if (lst_q) begin
							state_d = S_UNLINK;
						end else begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						// Touch, or reclaim with a keep entry: an entry already at the
						// head stays where it is.
						if (move_cmd && lst_q && link_is_ref(prev_rd)) begin
							state_d = S_UNLINK;
						end else if (cmd_q == CMD_TOUCH && inr_q && !lst_q) begin
							state_d = S_SELF;
						end else begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_UNLINK: begin
				if (link_is_ref(next_rd)) begin
					prev_we    = 1'b1;
					prev_waddr = IDX_W'(next_rd);
					prev_wdata = prev_rd;
				end else begin
					tail_d = prev_rd;
				end
				if (link_is_ref(prev_rd)) begin
					next_we    = 1'b1;
					next_waddr = IDX_W'(prev_rd);
					next_wdata = next_rd;
				end else begin
					head_d = next_rd;
				end
				lst_clr = 1'b1;
				if (cmd_q == CMD_REMOVE) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SELF;
				end
			end
			S_SELF: begin
				next_we    = 1'b1;
				next_wdata = head_q;
				prev_we    = 1'b1;
				prev_wdata = NULL_LINK;
				lst_set    = 1'b1;
				state_d    = S_LINK_HEAD;
			end
			S_LINK_HEAD: begin
				if (link_is_ref(head_q)) begin
					prev_we    = 1'b1;
					prev_waddr = IDX_W'(head_q);
					prev_wdata = self_link;
				end else begin
					tail_d = self_link;
				end
				head_d  = self_link;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			head_q   <= NULL_LINK;
			tail_q   <= NULL_LINK;
			done_q   <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			done_q <= done_d;
			if (lst_clear_all) begin
				listed_q <= '0;
			end else if (lst_set) begin
				listed_q[idx_q] <= 1'b1;
			end else if (lst_clr) begin
				listed_q[idx_q] <= 1'b0;
			end
		end
	end

	// Result beat: all sources are settled registers during the done cycle.
	assign done         = done_q;
	assign victim_valid = (cmd_q == CMD_RECLAIM) && link_is_ref(tail_q)
		&& !(keep_q && inr_q && (IDX_W'(tail_q) == idx_q));
	assign victim_id    = victim_valid ? ID_W'(tail_q) : '0;
	assign was_listed   = (cmd_q == CMD_TOUCH || cmd_q == CMD_REMOVE) ? lst_q
		: ((cmd_q == CMD_RECLAIM) ? (keep_q && lst_q) : 1'b0);
	assign list_empty   = !link_is_ref(head_q);

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result beat while the sequencer is still working");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EVAL))
		else $error("accepted command did not move to evaluation");

	a_ends_match: assert property (@(posedge clk) disable iff (!arst_n)
		link_is_ref(head_q) == link_is_ref(tail_q))
		else $error("head and tail disagree on whether the list is empty");

	a_members_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ((listed_q == '0) == !link_is_ref(head_q)))
		else $error("membership bits disagree with the head pointer");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy))
		else $error("result beat without a command in progress");
`endif

endmodule

FILE: hdl/lrut_link_ram.sv
// ----------------------------------------------------------------------------
// LRU link memory
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read. Contents are undefined after reset.
// ----------------------------------------------------------------------------
module lrut_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sim/tb_lru_list_tracker.sv
// ----------------------------------------------------------------------------
// LRU list tracker testbench
// Drives touch, remove, reclaim and clear commands through the start/busy
// handshake, keeps its own linked-list model of the recency order and checks
// every done beat field by field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module tb_lru_list_tracker;
	import lrut_pkg::*;

	typedef struct packed {
		cmd_t            op;
		logic [ID_W-1:0] id;
		logic            keep;
		logic [7:0]      gap;
		logic            drain;
	} cmd_item_t;

	typedef struct packed {
		logic            victim_valid;
		logic [ID_W-1:0] victim_id;
		logic            was_listed;
		logic            list_empty;
	} outcome_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	logic [1:0]      cmd = CMD_TOUCH;
	logic [ID_W-1:0] entry_id = '0;
	logic            keep_valid = 1'b0;
	logic            done;
	logic            victim_valid;
	logic [ID_W-1:0] victim_id;
	logic            was_listed;
	logic            list_empty;

	cmd_item_t cmd_q[$];
	outcome_t  outcome_q[$];
	cmd_item_t cur_item;
	int        gap_left;
	int        accepted_cnt;
	int        done_cnt;
	int        err_cnt = 0;

	// Model of the recency list.
	logic [LINK_W-1:0] lru_next [ENTRIES];
	logic [LINK_W-1:0] lru_prev [ENTRIES];
	logic [ENTRIES-1:0] lru_member;
	logic [LINK_W-1:0] lru_head;
	logic [LINK_W-1:0] lru_tail;

	lru_list_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.entry_id     (entry_id),
		.keep_valid   (keep_valid),
		.done         (done),
		.victim_valid (victim_valid),
		.victim_id    (victim_id),
		.was_listed   (was_listed),
		.list_empty   (list_empty)
	);

	always #2 clk = ~clk;

	function automatic void detach_entry(input logic [ID_W-1:0] e);
		logic [LINK_W-1:0] n;
		logic [LINK_W-1:0] p;
		if (!lru_member[e])
			return;
		n = lru_next[e];
		p = lru_prev[e];
		if (n != NULL_LINK)
			lru_prev[n[ID_W-1:0]] = p;
		else
			lru_tail = p;
		if (p != NULL_LINK)
			lru_next[p[ID_W-1:0]] = n;
		else
			lru_head = n;
		lru_member[e] = 1'b0;
	endfunction

	function automatic void promote_entry(input logic [ID_W-1:0] e);
		if (lru_member[e]) begin
			// Already at the head: nothing moves.
			if (lru_prev[e] == NULL_LINK)
				return;
			detach_entry(e);
		end
		lru_member[e] = 1'b1;
		lru_next[e] = lru_head;
		lru_prev[e] = NULL_LINK;
		if (lru_head != NULL_LINK)
			lru_prev[lru_head[ID_W-1:0]] = LINK_W'(e);
		else
			lru_tail = LINK_W'(e);
		lru_head = LINK_W'(e);
	endfunction

	function automatic outcome_t apply_command(input cmd_t op, input logic [ID_W-1:0] id,
			input logic keep);
		outcome_t res;
		logic listed;
		res = '0;
		listed = lru_member[id];
		case (op)
			CMD_TOUCH: begin
				res.was_listed = listed;
				promote_entry(id);
			end
			CMD_REMOVE: begin
				res.was_listed = listed;
				detach_entry(id);
			end
			CMD_RECLAIM: begin
				if (keep && listed) begin
					res.was_listed = 1'b1;
					promote_entry(id);
				end
				if (lru_tail != NULL_LINK && !(keep && lru_tail == LINK_W'(id))) begin
					res.victim_valid = 1'b1;
					res.victim_id = lru_tail[ID_W-1:0];
				end
			end
			default: begin
				lru_member = '0;
				lru_head = NULL_LINK;
				lru_tail = NULL_LINK;
			end
		endcase
		res.list_empty = (lru_head == NULL_LINK);
		return res;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// Driver: a command beat goes out once the previous one is taken and its gap is over.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_TOUCH;
			entry_id <= '0;
			keep_valid <= 1'b0;
			gap_left = 0;
			accepted_cnt = 0;
			cur_item = '0;
			lru_member = '0;
			lru_head = NULL_LINK;
			lru_tail = NULL_LINK;
		end else begin
			if (start && !busy) begin
				outcome_q.push_back(apply_command(cmd_t'(cmd), entry_id, keep_valid));
				accepted_cnt++;
				gap_left = int'(cur_item.gap);
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_q.size() > 0 &&
						!(cmd_q[0].drain && accepted_cnt != done_cnt)) begin
					cur_item = cmd_q.pop_front();
					cmd <= cur_item.op;
					entry_id <= cur_item.id;
					keep_valid <= cur_item.keep;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done beat is taken at the edge that ends its cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_cnt <= 0;
		end else if (done) begin
			done_cnt <= done_cnt + 1;
			if (outcome_q.size() == 0) begin
				$display("%0t: result beat with no outcome pending, expected none actual %0d",
					$time, {victim_valid, victim_id, was_listed, list_empty});
				err_cnt++;
			end else begin
				outcome_t exp_r;
				exp_r = outcome_q.pop_front();
				check_field("victim_valid", int'(exp_r.victim_valid), int'(victim_valid));
				check_field("victim_id", int'(exp_r.victim_id), int'(victim_id));
				check_field("was_listed", int'(exp_r.was_listed), int'(was_listed));
				check_field("list_empty", int'(exp_r.list_empty), int'(list_empty));
			end
		end
	end

	function automatic logic [7:0] pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'd0;
		else if (r < 90)
			return 8'($urandom_range(1, 3));
		else
			return 8'($urandom_range(8, 40));
	endfunction

	task automatic queue_cmd(input cmd_t op, input int id, input logic keep,
			input logic [7:0] gap, input logic drain);
		cmd_item_t it;
		it.op = op;
		it.id = ID_W'(id);
		it.keep = keep;
		it.gap = gap;
		it.drain = drain;
		cmd_q.push_back(it);
	endtask

	initial begin
		int perm [ENTRIES];
		int pool_hi;
		int base;
		int len;
		int r;
		int j;
		int tmp;
		bit quiet;
		cmd_t op;
		logic keep;

		// Directed opening: empty list, head touches, sole keep entry, absent keep,
		// tail moves, removal down to empty and clears.
		queue_cmd(CMD_RECLAIM, 63, 1'b0, 0, 1'b0);
		queue_cmd(CMD_RECLAIM, 0, 1'b1, 0, 1'b0);
		queue_cmd(CMD_REMOVE, 63, 1'b1, 1, 1'b0);
		queue_cmd(CMD_TOUCH, 0, 1'b0, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 0, 1'b1, 2, 1'b0);
		queue_cmd(CMD_RECLAIM, 0, 1'b1, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 63, 1'b0, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 5, 1'b0, 3, 1'b0);
		queue_cmd(CMD_RECLAIM, 5, 1'b0, 0, 1'b0);
		queue_cmd(CMD_RECLAIM, 0, 1'b1, 0, 1'b0);
		queue_cmd(CMD_RECLAIM, 42, 1'b1, 1, 1'b0);
		queue_cmd(CMD_TOUCH, 63, 1'b1, 0, 1'b0);
		queue_cmd(CMD_RECLAIM, 5, 1'b1, 0, 1'b0);
		queue_cmd(CMD_REMOVE, 5, 1'b0, 0, 1'b0);
		queue_cmd(CMD_REMOVE, 0, 1'b0, 2, 1'b0);
		queue_cmd(CMD_REMOVE, 63, 1'b1, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 1, 1'b0, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 2, 1'b0, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 3, 1'b0, 0, 1'b0);
		queue_cmd(CMD_CLEAR, 42, 1'b1, 0, 1'b0);
		queue_cmd(CMD_CLEAR, 21, 1'b0, 1, 1'b0);
		queue_cmd(CMD_RECLAIM, 2, 1'b1, 0, 1'b0);
		queue_cmd(CMD_TOUCH, 62, 1'b1, 0, 1'b0);

		// Random phases: each works on a window of ids so that moves hit listed
		// entries often; some phases first fill the whole list.
		while (cmd_q.size() < 1700) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
				0: pool_hi = 1;
				1: pool_hi = 3;
				2: pool_hi = 7;
				3: pool_hi = 15;
				default: pool_hi = 63;
			endcase
			base = $urandom_range(0, 63 - pool_hi);
			len = $urandom_range(20, 80);
			if ($urandom_range(0, 7) == 0) begin
				for (int i = 0; i < ENTRIES; i++)
					perm[i] = i;
				for (int i = ENTRIES - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				for (int i = 0; i < ENTRIES; i++)
					queue_cmd(CMD_TOUCH, perm[i], 1'($urandom_range(0, 1)),
						quiet ? 8'd0 : pick_gap(), 1'b0);
			end
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					op = CMD_TOUCH;
				else if (r < 70)
					op = CMD_REMOVE;
				else if (r < 97)
					op = CMD_RECLAIM;
				else
					op = CMD_CLEAR;
				keep = (op == CMD_RECLAIM) ? ($urandom_range(0, 9) < 7)
					: 1'($urandom_range(0, 1));
				queue_cmd(op, base + $urandom_range(0, pool_hi), keep,
					quiet ? 8'd0 : pick_gap(), ($urandom_range(0, 199) == 0));
			end
		end
		// Make sure the sender waits for the block to drain at least once.
		cmd_q[30].drain = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
